/* rtl/m7fta_pkg.sv */
// Shared types and constants for the mode 7 floor texel address block.
`timescale 1ns / 1ps
package m7fta_pkg;

    localparam int NUM_REGS = 8;

    typedef enum logic [2:0] {
        REG_FAR_LEFT_X   = 3'd0,
        REG_FAR_LEFT_Y   = 3'd1,
        REG_NEAR_LEFT_X  = 3'd2,
        REG_NEAR_LEFT_Y  = 3'd3,
        REG_FAR_RIGHT_X  = 3'd4,
        REG_FAR_RIGHT_Y  = 3'd5,
        REG_NEAR_RIGHT_X = 3'd6,
        REG_NEAR_RIGHT_Y = 3'd7
    } reg_idx_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [8:0]        screen_x;
        logic [7:0]        ground_row;
        logic signed [7:0] sky_row;
        logic [7:0]        row;
        logic              zero_row;
    } front_item_t;

    // Finished result
    typedef struct packed {
        logic [8:0]        screen_x;
        logic [7:0]        ground_row;
        logic signed [7:0] sky_row;
        logic [16:0]       texel_index;
        logic              texel_valid;
    } result_t;

endpackage

/* rtl/m7fta_front.sv */
// Front stage: accept pixel words, compute screen rows and flag zero rows.
`timescale 1ns / 1ps
module m7fta_front
    import m7fta_pkg::*;
#(
    parameter int HROW = 80
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [8:0]  pixel_x,
    input  logic [7:0]  row_index,
    output logic        out_valid,
    input  logic        out_ready,
    output front_item_t out_item
);

    localparam logic [7:0] HROW8 = 8'(HROW);

    logic        valid_reg;
    front_item_t item_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Hold until the queue takes the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.screen_x   <= pixel_x;
            item_reg.ground_row <= HROW8 + row_index;
            item_reg.sky_row    <= HROW8 - row_index;
            item_reg.row        <= row_index;
            item_reg.zero_row   <= (row_index == 8'd0);
        end
    end

endmodule

/* rtl/m7fta_queue.sv */
// Two-entry queue between front and back.
`timescale 1ns / 1ps
module m7fta_queue
    import m7fta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  front_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output front_item_t out_item
);

    front_item_t mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* rtl/m7fta_back.sv */
// Back pipeline: perspective sample, exact division, texel index.
`timescale 1ns / 1ps
module m7fta_back
    import m7fta_pkg::*;
#(
    parameter int HROW       = 80,
    parameter int SCR_W      = 320,
    parameter int TEX_W      = 320,
    parameter int TEX_H      = 240
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  front_item_t        in_item,
    input  logic signed [23:0] regs [NUM_REGS],
    output logic               out_valid,
    input  logic               out_ready,
    output result_t            out_item
);

    // numerator magnitude bound: about 2^24 * 2^11 * 2^10 * 2^10 < 2^58
    localparam int NW   = 64;
    localparam int DW   = 8 + 11 + 16;   // y * w * 2^16
    localparam int QW   = 40;            // quotient bits produced
    localparam longint TEXN = longint'(TEX_W) * longint'(TEX_H);

    typedef struct packed {
        front_item_t       it;
        logic signed [NW-1:0] numx, numy;
        logic [DW-1:0]     den;
    } p1_t;

    typedef struct packed {
        front_item_t       it;
        logic              negx, negy;
        logic [NW-1:0]     remx, remy;
        logic [QW-1:0]     qx, qy;
        logic [DW-1:0]     den;
    } dv_t;

    logic adv;
    result_t res_reg;
    logic    res_v_reg;

    // Whole pipe moves together; output register ends it
    assign adv       = !res_v_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = res_v_reg;
    assign out_item  = res_reg;

    // Stage A: corner differences
    logic                  a_v_reg;
    front_item_t           a_it_reg;
    logic signed [25:0]    a_dlx, a_dly, a_dnx, a_dny, a_ddx, a_ddy;
    logic signed [23:0]    a_nlx, a_nly;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) a_v_reg <= 1'b0;
        else if (adv) a_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_it_reg <= in_item;
            a_nlx <= regs[REG_NEAR_LEFT_X];
            a_nly <= regs[REG_NEAR_LEFT_Y];
            a_dlx <= 26'(regs[REG_FAR_LEFT_X]) - 26'(regs[REG_NEAR_LEFT_X]);
            a_dly <= 26'(regs[REG_FAR_LEFT_Y]) - 26'(regs[REG_NEAR_LEFT_Y]);
            a_dnx <= 26'(regs[REG_NEAR_RIGHT_X]) - 26'(regs[REG_NEAR_LEFT_X]);
            a_dny <= 26'(regs[REG_NEAR_RIGHT_Y]) - 26'(regs[REG_NEAR_LEFT_Y]);
            a_ddx <= (26'(regs[REG_FAR_RIGHT_X]) - 26'(regs[REG_NEAR_RIGHT_X]))
                   - (26'(regs[REG_FAR_LEFT_X]) - 26'(regs[REG_NEAR_LEFT_X]));
            a_ddy <= (26'(regs[REG_FAR_RIGHT_Y]) - 26'(regs[REG_NEAR_RIGHT_Y]))
                   - (26'(regs[REG_FAR_LEFT_Y]) - 26'(regs[REG_NEAR_LEFT_Y]));
        end
    end

    // Stage B: row terms, each a sum of two products
    logic               b_v_reg;
    front_item_t        b_it_reg;
    logic signed [47:0] b_lx, b_ly, b_sx, b_sy;
    logic signed [9:0]  b_x;

    localparam logic signed [11:0] H12 = 12'(HROW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) b_v_reg <= 1'b0;
        else if (adv) b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_it_reg <= a_it_reg;
            b_x  <= $signed({1'b0, a_it_reg.screen_x});
            b_lx <= 48'(a_nlx * $signed({1'b0, a_it_reg.row})) + 48'(a_dlx * H12);
            b_ly <= 48'(a_nly * $signed({1'b0, a_it_reg.row})) + 48'(a_dly * H12);
            b_sx <= 48'(a_dnx * $signed({1'b0, a_it_reg.row})) + 48'(a_ddx * H12);
            b_sy <= 48'(a_dny * $signed({1'b0, a_it_reg.row})) + 48'(a_ddy * H12);
        end
    end

    // Stage C: combine across x
    localparam logic signed [12:0] W13 = 13'(SCR_W);
    logic               c_v_reg;
    front_item_t        c_it_reg;
    logic signed [NW-1:0] c_nx, c_ny;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) c_v_reg <= 1'b0;
        else if (adv) c_v_reg <= b_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_it_reg <= b_it_reg;
            c_nx <= NW'(b_lx * W13) + NW'(b_sx * b_x);
            c_ny <= NW'(b_ly * W13) + NW'(b_sy * b_x);
        end
    end

    // Stage D: scale and bias, denominator
    localparam logic signed [12:0] TW13 = 13'(TEX_W);
    localparam logic signed [12:0] TH13 = 13'(TEX_H);
    p1_t  d_reg;
    logic d_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) d_v_reg <= 1'b0;
        else if (adv) d_v_reg <= c_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg.it   <= c_it_reg;
            d_reg.den  <= DW'({c_it_reg.row, 16'd0}) * DW'(SCR_W);
            d_reg.numx <= NW'(c_nx * TW13);
            d_reg.numy <= NW'(c_ny * TH13) - NW'({c_it_reg.row, 16'd0}) * NW'(SCR_W);
        end
    end

    // Divider stages: magnitude, one quotient bit per stage
    dv_t         dv [QW+1];
    logic [QW:0] dv_v_reg;

    // Advance valid flags through the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) dv_v_reg <= '0;
        else if (adv) dv_v_reg <= {dv_v_reg[QW-1:0], d_v_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv[0].it   <= d_reg.it;
            dv[0].den  <= d_reg.den;
            dv[0].negx <= d_reg.numx[NW-1];
            dv[0].negy <= d_reg.numy[NW-1];
            dv[0].remx <= d_reg.numx[NW-1] ? NW'(-d_reg.numx) : NW'(d_reg.numx);
            dv[0].remy <= d_reg.numy[NW-1] ? NW'(-d_reg.numy) : NW'(d_reg.numy);
            dv[0].qx   <= '0;
            dv[0].qy   <= '0;
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_div
        localparam int SH = QW - 1 - s;
        logic [NW+QW-1:0] dsh;
        logic             gx, gy;
        assign dsh = (NW+QW)'(dv[s].den) << SH;
        assign gx  = {{QW{1'b0}}, dv[s].remx} >= dsh;
        assign gy  = {{QW{1'b0}}, dv[s].remy} >= dsh;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv[s+1].it   <= dv[s].it;
                dv[s+1].den  <= dv[s].den;
                dv[s+1].negx <= dv[s].negx;
                dv[s+1].negy <= dv[s].negy;
                dv[s+1].remx <= gx ? NW'(dv[s].remx - NW'(dsh)) : dv[s].remx;
                dv[s+1].remy <= gy ? NW'(dv[s].remy - NW'(dsh)) : dv[s].remy;
                dv[s+1].qx   <= dv[s].qx | (QW'(gx) << SH);
                dv[s+1].qy   <= dv[s].qy | (QW'(gy) << SH);
            end
        end
    end

    // Final: signed quotients, flatten, range check
    logic signed [QW:0]   fx, fy;
    logic signed [63:0]   flat;
    logic                 inr;
    localparam logic signed [13:0] TW14 = 14'(TEX_W);

    assign fx   = dv[QW].negx ? -$signed({1'b0, dv[QW].qx}) : $signed({1'b0, dv[QW].qx});
    assign fy   = dv[QW].negy ? -$signed({1'b0, dv[QW].qy}) : $signed({1'b0, dv[QW].qy});
    assign flat = 64'(fy * TW14) + 64'(fx);
    assign inr  = !dv[QW].it.zero_row && (flat >= 0) && (flat < 64'(TEXN));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) res_v_reg <= 1'b0;
        else if (adv) res_v_reg <= dv_v_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg.screen_x    <= dv[QW].it.screen_x;
            res_reg.ground_row  <= dv[QW].it.ground_row;
            res_reg.sky_row     <= dv[QW].it.sky_row;
            res_reg.texel_valid <= inr;
            res_reg.texel_index <= inr ? flat[16:0] : 17'd0;
        end
    end

endmodule

/* rtl/mode7_floor_texel_address_top.sv */
// Top level of the mode 7 floor texel address block.
`timescale 1ns / 1ps
// Mode 7 floor texel address generator.
// Slave stream carries one pixel word {row_index, pixel_x}; master stream
// returns {texel_valid, texel_index, sky_row, ground_row, screen_x}.
// Frustum corners are loaded through cfg_we/cfg_index/cfg_data while idle;
// the user must ensure that; the block does not check. One word per clock
// while the receiver accepts. The path is a front register, a two-entry
// queue, five arithmetic stages, a 40-stage restoring divider producing
// one quotient bit per stage, and an output register. The divider pipeline
// sets the latency. When the receiver stalls, the whole back pipe holds;
// the queue fills and then the front deasserts s_axis_tready.
// Reset clears all valid flags and the corner registers to zero.
// Row zero and indexes outside the texture give texel_valid low, index 0.
module mode7_floor_texel_address_top
    import m7fta_pkg::*;
#(
    parameter int SCREEN_WIDTH   = 320,
    parameter int SCREEN_HEIGHT  = 240,
    parameter int HORIZON_OFFSET = 160,
    parameter int TEX_WIDTH      = 320,
    parameter int TEX_HEIGHT     = 240
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel_x[8:0], row_index[16:9]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // screen_x, ground_row, sky_row,
                                        // texel_index, texel_valid
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int HROW = SCREEN_HEIGHT - HORIZON_OFFSET;

    logic signed [23:0] regs_reg [NUM_REGS];
    front_item_t f_item, q_item;
    logic f_v, f_r, q_v, q_r;
    result_t res;

    // Write corner registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++) regs_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    m7fta_front #(.HROW(HROW)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .pixel_x(s_axis_tdata[8:0]), .row_index(s_axis_tdata[16:9]),
        .out_valid(f_v), .out_ready(f_r), .out_item(f_item)
    );

    m7fta_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_v), .in_ready(f_r), .in_item(f_item),
        .out_valid(q_v), .out_ready(q_r), .out_item(q_item)
    );

    m7fta_back #(.HROW(HROW), .SCR_W(SCREEN_WIDTH), .TEX_W(TEX_WIDTH),
                 .TEX_H(TEX_HEIGHT)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_v), .in_ready(q_r), .in_item(q_item),
        .regs(regs_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_item(res)
    );

    assign m_axis_tdata = {5'd0, res.texel_valid, res.texel_index, res.sky_row,
                           res.ground_row, res.screen_x};

    // An output word with texel_valid low always carries index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !res.texel_valid |-> res.texel_index == 17'd0)
        else $error("invalid texel with nonzero index");

    // Stalled output holds its word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");

endmodule
